/* hw/rtl/psaw_pkg.sv */
// shared constants, types and codes for the polyblep sawtooth oscillator
package psaw_pkg;

  localparam int PHASE_BITS    = 24;
  localparam int SAMPLE_BITS   = 16;
  localparam int RECIP_BITS    = 32;
  localparam int RECIP_FRAC    = 16;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_IDX_BITS  = 2;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_BITS     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);
  localparam int PROD_BITS     = PHASE_BITS + RECIP_BITS;
  localparam int POS_BITS      = PROD_BITS - RECIP_FRAC;
  localparam int SUM_BITS      = PHASE_BITS + 4;
  localparam int SHIFT         = PHASE_BITS - (SAMPLE_BITS - 1);
  localparam int RES_BITS      = SUM_BITS - SHIFT;

  localparam logic [PHASE_BITS:0]   PH_ONE  = {1'b1, {PHASE_BITS{1'b0}}};
  localparam logic [PHASE_BITS-1:0] PH_HALF = {1'b1, {(PHASE_BITS - 1){1'b0}}};

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_PHASE_STEP  = 2'd0,
    CFG_BLEND_WIDTH = 2'd1,
    CFG_BLEND_RECIP = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    EDGE_NONE  = 2'd0,
    EDGE_START = 2'd1,
    EDGE_END   = 2'd2
  } edge_kind_t;

  typedef struct packed {
    edge_kind_t            kind;
    logic [PHASE_BITS-1:0] w;
    logic [PHASE_BITS-1:0] span;
  } blep_item_t;

endpackage

/* hw/rtl/polyblep_saw_oscillator_top.sv */
// top level of the polyblep sawtooth oscillator
// usage:
//   configure phase_step, blend_width and blend_recip through the write port
//   (cfg_we, cfg_index, cfg_data) while the block is idle.
//   each transfer on the input channel (in_valid/in_ready) carries a tick bit;
//   a tick of one yields one sample on the output channel (out_valid/out_ready)
//   and advances the phase by phase_step, a tick of zero yields nothing.
// path: a sample goes from its tick transfer through the queue, the item register,
//   the multiply, the square and the output register when the back end is free.
// back end: the sequencer runs the reciprocal multiply and the square on one item
//   at a time and takes no new item from the queue until its sample is loaded.
//   the front end keeps taking ticks until the two-entry queue is full.
// reset: synchronous, clears the phase accumulator, the configuration registers, the queue
//   and the output valid.
// stall: while out_ready is low the finished sample holds in the output
//   register, the back end waits, the queue fills and then in_ready drops.
module polyblep_saw_oscillator_top (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic                                    tick,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [psaw_pkg::SAMPLE_BITS-1:0] sample_out,
  input  logic                                    cfg_we,
  input  logic [psaw_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [psaw_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

  logic [psaw_pkg::PHASE_BITS-1:0] phase_step;
  logic [psaw_pkg::PHASE_BITS-1:0] blend_width;
  logic [psaw_pkg::RECIP_BITS-1:0] blend_recip;
  logic                            push_valid;
  logic                            push_ready;
  psaw_pkg::blep_item_t            push_item;
  logic                            pop_valid;
  logic                            pop_ready;
  psaw_pkg::blep_item_t            pop_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step  <= '0;
      blend_width <= '0;
      blend_recip <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        psaw_pkg::CFG_PHASE_STEP:  phase_step  <= cfg_data[psaw_pkg::PHASE_BITS-1:0];
        psaw_pkg::CFG_BLEND_WIDTH: blend_width <= cfg_data[psaw_pkg::PHASE_BITS-1:0];
        psaw_pkg::CFG_BLEND_RECIP: blend_recip <= cfg_data[psaw_pkg::RECIP_BITS-1:0];
        default: ;
      endcase
    end
  end

  psaw_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .tick        (tick),
    .phase_step  (phase_step),
    .blend_width (blend_width),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_item   (push_item)
  );

  psaw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  psaw_back u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_item    (pop_item),
    .blend_recip (blend_recip),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .sample_out  (sample_out)
  );

endmodule

/* hw/rtl/psaw_front.sv */
// front end: takes ticks, forms the wrapped phase and classifies the edge region
module psaw_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              tick,
  input  logic [psaw_pkg::PHASE_BITS-1:0]   phase_step,
  input  logic [psaw_pkg::PHASE_BITS-1:0]   blend_width,
  output logic                              push_valid,
  input  logic                              push_ready,
  output psaw_pkg::blep_item_t              push_item
);

  logic [psaw_pkg::PHASE_BITS-1:0] phase_acc;
  logic [psaw_pkg::PHASE_BITS-1:0] phase_acc_next;
  logic [psaw_pkg::PHASE_BITS-1:0] w;
  logic [psaw_pkg::PHASE_BITS:0]   end_limit;
  logic [psaw_pkg::PHASE_BITS:0]   end_span;
  logic                            near_start;
  logic                            near_end;

  assign in_ready   = push_ready;
  assign push_valid = in_valid && push_ready && tick;

  assign w          = phase_acc + psaw_pkg::PH_HALF;
  assign end_limit  = psaw_pkg::PH_ONE - {1'b0, blend_width};
  assign end_span   = psaw_pkg::PH_ONE - {1'b0, w};
  assign near_start = w < blend_width;
  assign near_end   = {1'b0, w} > end_limit;

  always_comb begin
    push_item.w = w;
    if (near_start) begin
      push_item.kind = psaw_pkg::EDGE_START;
      push_item.span = w;
    end else if (near_end) begin
      push_item.kind = psaw_pkg::EDGE_END;
      push_item.span = end_span[psaw_pkg::PHASE_BITS-1:0];
    end else begin
      push_item.kind = psaw_pkg::EDGE_NONE;
      push_item.span = '0;
    end
  end

  assign phase_acc_next = push_valid ? (phase_acc + phase_step) : phase_acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc <= '0;
    end else begin
      phase_acc <= phase_acc_next;
    end
  end

endmodule

/* hw/rtl/psaw_queue.sv */
// short queue between the front end and the correction back end
module psaw_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  psaw_pkg::blep_item_t push_item,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output psaw_pkg::blep_item_t pop_item
);

  psaw_pkg::blep_item_t           entries [psaw_pkg::QUEUE_DEPTH];
  logic [psaw_pkg::QPTR_BITS-1:0] wr_ptr;
  logic [psaw_pkg::QPTR_BITS-1:0] rd_ptr;
  logic [psaw_pkg::QCNT_BITS-1:0] count;
  logic [psaw_pkg::QCNT_BITS-1:0] count_next;
  logic                           do_push;
  logic                           do_pop;

  assign push_ready = count != psaw_pkg::QCNT_BITS'(psaw_pkg::QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_item   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    count_next = count;
    if (do_push && !do_pop) begin
      count_next = count + 1'b1;
    end else if (do_pop && !do_push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (do_push) begin
        wr_ptr <= (wr_ptr == psaw_pkg::QPTR_BITS'(psaw_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                                : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == psaw_pkg::QPTR_BITS'(psaw_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                                : rd_ptr + 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (count == psaw_pkg::QCNT_BITS'(psaw_pkg::QUEUE_DEPTH)) |-> !do_push)
    else $error("queue written while full");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count missed a write");

endmodule

/* hw/rtl/psaw_back.sv */
// back end: scales the edge distance, squares it and forms the saturated sample
module psaw_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 pop_valid,
  output logic                                 pop_ready,
  input  psaw_pkg::blep_item_t                 pop_item,
  input  logic [psaw_pkg::RECIP_BITS-1:0]      blend_recip,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [psaw_pkg::SAMPLE_BITS-1:0] sample_out
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_SQ   = 4'b0100,
    S_DONE = 4'b1000
  } back_state_t;

  back_state_t                        state;
  back_state_t                        state_next;
  psaw_pkg::blep_item_t               item;
  logic [psaw_pkg::PROD_BITS-1:0]     prod;
  logic                               pos_sat;
  logic [psaw_pkg::PHASE_BITS-1:0]    pos_low;
  logic [2*psaw_pkg::PHASE_BITS-1:0]  sq_prod;
  logic [psaw_pkg::PHASE_BITS-1:0]    prod_low;
  logic [psaw_pkg::PHASE_BITS:0]      pos;
  logic [psaw_pkg::PHASE_BITS:0]      sq;
  logic signed [psaw_pkg::SUM_BITS-1:0] one_s;
  logic signed [psaw_pkg::SUM_BITS-1:0] pos_s;
  logic signed [psaw_pkg::SUM_BITS-1:0] sq_s;
  logic signed [psaw_pkg::SUM_BITS-1:0] naive;
  logic signed [psaw_pkg::SUM_BITS-1:0] corr;
  logic signed [psaw_pkg::SUM_BITS-1:0] diff;
  logic signed [psaw_pkg::RES_BITS-1:0] res;
  logic signed [psaw_pkg::SAMPLE_BITS-1:0] sample_next;
  logic                               load;

  assign pop_ready = state == S_IDLE;
  assign load      = (state == S_DONE) && (!out_valid || out_ready);
  assign prod_low  = prod[psaw_pkg::RECIP_FRAC +: psaw_pkg::PHASE_BITS];

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (pop_valid) state_next = S_MUL;
      S_MUL:  state_next = S_SQ;
      S_SQ:   state_next = S_DONE;
      S_DONE: if (load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // correction and rescale
  always_comb begin
    pos   = pos_sat ? psaw_pkg::PH_ONE : {1'b0, pos_low};
    sq    = pos_sat ? psaw_pkg::PH_ONE
                    : {1'b0, sq_prod[2*psaw_pkg::PHASE_BITS-1:psaw_pkg::PHASE_BITS]};
    one_s = $signed(psaw_pkg::SUM_BITS'(psaw_pkg::PH_ONE));
    pos_s = $signed(psaw_pkg::SUM_BITS'(pos));
    sq_s  = $signed(psaw_pkg::SUM_BITS'(sq));
    naive = $signed(psaw_pkg::SUM_BITS'({item.w, 1'b0})) - one_s;
    case (item.kind)
      psaw_pkg::EDGE_START: corr = (pos_s <<< 1) - sq_s - one_s;
      psaw_pkg::EDGE_END:   corr = one_s - (pos_s <<< 1) + sq_s;
      default:              corr = '0;
    endcase
    diff = naive - corr;
    res  = diff[psaw_pkg::SUM_BITS-1:psaw_pkg::SHIFT];
    if ((&res[psaw_pkg::RES_BITS-1:psaw_pkg::SAMPLE_BITS-1]) ||
        !(|res[psaw_pkg::RES_BITS-1:psaw_pkg::SAMPLE_BITS-1])) begin
      sample_next = res[psaw_pkg::SAMPLE_BITS-1:0];
    end else if (res[psaw_pkg::RES_BITS-1]) begin
      sample_next = {1'b1, {(psaw_pkg::SAMPLE_BITS - 1){1'b0}}};
    end else begin
      sample_next = {1'b0, {(psaw_pkg::SAMPLE_BITS - 1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && pop_valid) begin
      item <= pop_item;
    end
    if (state == S_MUL) begin
      prod <= psaw_pkg::PROD_BITS'(item.span) * psaw_pkg::PROD_BITS'(blend_recip);
    end
    if (state == S_SQ) begin
      pos_sat <= prod[psaw_pkg::PROD_BITS-1:psaw_pkg::RECIP_FRAC]
                 >= psaw_pkg::POS_BITS'(psaw_pkg::PH_ONE);
      pos_low <= prod_low;
      sq_prod <= (2*psaw_pkg::PHASE_BITS)'(prod_low) * (2*psaw_pkg::PHASE_BITS)'(prod_low);
    end
    if (load) begin
      sample_out <= sample_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_load_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("sample shown without finishing the correction");

  a_pop_starts_mul: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && pop_valid) |=> (state == S_MUL))
    else $error("queue transfer did not start the multiply");

endmodule
